>>> hdl/ipa_pkg.sv
package ipa_pkg;

  // ascii codes used by the formatter
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  // 'A' minus ten, so that a digit of ten maps to 'A'
  localparam logic [6:0] CH_HEX_BASE = 7'h37;

  // conversion modes
  localparam logic [1:0] MODE_SDEC = 2'd0;

  // digit register: ten bcd digits cover the full 32-bit range
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIG_W      = 4 * NUM_DIGITS;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned VAL_W      = 32;

  // one input item
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [4:0]  min_digits;
    logic [5:0]  field_width;
    logic        left_justify;
    logic        pad_zero;
    logic        force_sign;
  } ipa_in_t;

  // one result item
  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } ipa_out_t;

  // formatter sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_PRE,
    ST_SIGN,
    ST_ZPAD,
    ST_PREC,
    ST_DIGIT,
    ST_POST
  } fmt_state_e;

  // digit converter states
  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DABBLE,
    CV_NORM,
    CV_HOLD
  } conv_state_e;

  // commands to the digit converter
  typedef struct packed {
    logic        start;
    logic        hex;
    logic [31:0] mag;
    logic        pop;
  } conv_cmd_t;

  // status from the digit converter
  typedef struct packed {
    logic       done;
    logic [3:0] digit_cnt;
    logic [3:0] top_digit;
  } conv_sts_t;

  // glyph for one digit, uppercase for hex
  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    if (d < 4'd10) begin
      g = CH_ZERO + {3'b000, d};
    end else begin
      g = CH_HEX_BASE + {3'b000, d};
    end
    return g;
  endfunction

endpackage

>>> hdl/integer_to_padded_ascii_core.sv
// Integer to padded ascii formatter.
// The input channel takes one item (value, mode, precision, field width
// and flags); the output channel returns the formatted text one ascii
// character per transfer, in printf order, with last set on the final one.
// in_stall_o is high from the transfer of an item until its last character
// has been loaded into the output register; one item is formatted at a time.
// Steps: after the input transfer a decimal value is converted in the
// bit-serial bcd converter (hex skips this step), then leading zero digits
// are dropped (keeping at least one), the digits are handed over and a
// planning state sets the padding. Characters then leave at one per cycle
// while the output is not stalled; an empty padding phase still passes
// through its own state without a character.
// The output register is a single stage: while out_stall_i is high the
// character held there stays put and the sequencer waits.
// The next item may be transferred while the final character still waits.
// Reset clears the sequencer, the converter state and the output valid; the
// per item registers and the output payload are not reset.
module integer_to_padded_ascii_core #(
  parameter int unsigned MAX_FIELD = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ipa_pkg::ipa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ipa_pkg::ipa_out_t out_data_o
);

  localparam int unsigned FW_W = $clog2(MAX_FIELD + 1);
  localparam int unsigned CW   = (FW_W > 6) ? FW_W : 6;

  ipa_pkg::fmt_state_e state_q, state_d;
  ipa_pkg::conv_cmd_t  conv_cmd;
  ipa_pkg::conv_sts_t  conv_sts;
  ipa_pkg::ipa_out_t   out_q, out_d;

  logic            out_valid_q, out_valid_d;
  logic            in_acc, load, emit;
  logic            neg;
  logic [31:0]     mag;

  // per item registers
  logic            lj_q, zf_q, sign_q;
  logic [6:0]      sign_ch_q;
  logic [4:0]      min_q;
  logic [5:0]      fw_q;
  logic [FW_W-1:0] pad_q;
  logic [4:0]      prec_q;
  logic [3:0]      cnt_q;

  // planning signals
  logic [4:0]      width_p, prec_p;
  logic [FW_W-1:0] fw_sat, fwp, pad_p;
  logic [CW-1:0]   fwp_ext, width_ext;
  logic            post_en;

  assign in_stall_o = (state_q != ipa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load       = !out_valid_q || !out_stall_i;
  assign post_en    = lj_q && (pad_q != '0);

  // sign and magnitude of the incoming value
  assign neg = (in_data_i.mode == ipa_pkg::MODE_SDEC) && in_data_i.value[31];
  assign mag = neg ? (32'd0 - in_data_i.value) : in_data_i.value;

  // converter control
  always_comb begin
    conv_cmd.start = in_acc;
    conv_cmd.hex   = in_data_i.mode[1];
    conv_cmd.mag   = mag;
    conv_cmd.pop   = emit && (state_q == ipa_pkg::ST_DIGIT);
  end

  ipa_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (conv_cmd),
    .sts_o  (conv_sts)
  );

  // padding and precision counts once the digit count is known
  always_comb begin
    width_p   = (min_q > {1'b0, conv_sts.digit_cnt}) ? min_q : {1'b0, conv_sts.digit_cnt};
    prec_p    = width_p - {1'b0, conv_sts.digit_cnt};
    fw_sat    = (CW'(fw_q) > CW'(MAX_FIELD)) ? FW_W'(MAX_FIELD) : FW_W'(fw_q);
    fwp       = fw_sat - FW_W'(sign_q && (fw_sat != '0));
    fwp_ext   = CW'(fwp);
    width_ext = CW'(width_p);
    pad_p     = (fwp_ext > width_ext) ? FW_W'(fwp_ext - width_ext) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipa_pkg::ST_IDLE: begin
        if (in_acc) state_d = ipa_pkg::ST_CONV;
      end
      ipa_pkg::ST_CONV: begin
        if (conv_sts.done) state_d = ipa_pkg::ST_PLAN;
      end
      ipa_pkg::ST_PLAN: begin
        state_d = ipa_pkg::ST_PRE;
      end
      ipa_pkg::ST_PRE: begin
        if (lj_q || zf_q || pad_q == '0 || (load && pad_q == FW_W'(1))) begin
          state_d = ipa_pkg::ST_SIGN;
        end
      end
      ipa_pkg::ST_SIGN: begin
        if (!sign_q || load) state_d = ipa_pkg::ST_ZPAD;
      end
      ipa_pkg::ST_ZPAD: begin
        if (!zf_q || pad_q == '0 || (load && pad_q == FW_W'(1))) begin
          state_d = ipa_pkg::ST_PREC;
        end
      end
      ipa_pkg::ST_PREC: begin
        if (prec_q == '0 || (load && prec_q == 5'd1)) state_d = ipa_pkg::ST_DIGIT;
      end
      ipa_pkg::ST_DIGIT: begin
        if (load && cnt_q == 4'd1) begin
          state_d = post_en ? ipa_pkg::ST_POST : ipa_pkg::ST_IDLE;
        end
      end
      ipa_pkg::ST_POST: begin
        if (pad_q == '0 || (load && pad_q == FW_W'(1))) state_d = ipa_pkg::ST_IDLE;
      end
      default: state_d = ipa_pkg::ST_IDLE;
    endcase
  end

  // character selection per phase
  always_comb begin
    emit            = 1'b0;
    out_d.character = ipa_pkg::CH_SPACE;
    out_d.last      = 1'b0;
    case (state_q)
      ipa_pkg::ST_PRE: begin
        emit = load && !lj_q && !zf_q && (pad_q != '0);
      end
      ipa_pkg::ST_SIGN: begin
        emit            = load && sign_q;
        out_d.character = sign_ch_q;
      end
      ipa_pkg::ST_ZPAD: begin
        emit            = load && zf_q && (pad_q != '0);
        out_d.character = ipa_pkg::CH_ZERO;
      end
      ipa_pkg::ST_PREC: begin
        emit            = load && (prec_q != '0);
        out_d.character = ipa_pkg::CH_ZERO;
      end
      ipa_pkg::ST_DIGIT: begin
        emit            = load;
        out_d.character = ipa_pkg::digit_glyph(conv_sts.top_digit);
        out_d.last      = (cnt_q == 4'd1) && !post_en;
      end
      ipa_pkg::ST_POST: begin
        emit       = load && (pad_q != '0);
        out_d.last = (pad_q == FW_W'(1));
      end
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item fields, counters and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lj_q      <= in_data_i.left_justify;
      zf_q      <= in_data_i.pad_zero && (in_data_i.min_digits == '0) &&
                   !in_data_i.left_justify;
      sign_q    <= neg || ((in_data_i.mode == ipa_pkg::MODE_SDEC) && in_data_i.force_sign);
      sign_ch_q <= neg ? ipa_pkg::CH_MINUS : ipa_pkg::CH_PLUS;
      min_q     <= in_data_i.min_digits;
      fw_q      <= in_data_i.field_width;
    end
    if (state_q == ipa_pkg::ST_PLAN) begin
      pad_q  <= pad_p;
      prec_q <= prec_p;
      cnt_q  <= conv_sts.digit_cnt;
    end
    if (emit) begin
      out_q <= out_d;
      case (state_q)
        ipa_pkg::ST_PRE,
        ipa_pkg::ST_ZPAD,
        ipa_pkg::ST_POST:  pad_q  <= pad_q - FW_W'(1);
        ipa_pkg::ST_PREC:  prec_q <= prec_q - 5'd1;
        ipa_pkg::ST_DIGIT: cnt_q  <= cnt_q - 4'd1;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted item always starts with the conversion wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ipa_pkg::ST_CONV)
    else $error("item accepted but sequencer not converting");

  // the character marked last ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_d.last |=> state_q == ipa_pkg::ST_IDLE)
    else $error("sequencer still busy after last character");

  // digits are only read once the converter holds them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipa_pkg::ST_DIGIT |-> conv_sts.done && cnt_q != '0)
    else $error("digit phase without converted digits");

  // a non-final character leaving means the item is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |-> state_q != ipa_pkg::ST_IDLE)
    else $error("sequencer idle before item completed");

endmodule

>>> hdl/ipa_conv.sv
module ipa_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipa_pkg::conv_cmd_t cmd_i,
  output ipa_pkg::conv_sts_t sts_o
);

  ipa_pkg::conv_state_e state_q, state_d;

  logic [ipa_pkg::DIG_W-1:0] dig_q, dig_d;
  logic [ipa_pkg::VAL_W-1:0] bin_q, bin_d;
  logic [4:0]                bit_q, bit_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [ipa_pkg::DIG_W-1:0] dig_adj;
  logic                      top_zero;

  // add three to every bcd digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < ipa_pkg::NUM_DIGITS; k++) begin
      if (dig_q[4*k +: 4] >= 4'd5) begin
        dig_adj[4*k +: 4] = dig_q[4*k +: 4] + 4'd3;
      end else begin
        dig_adj[4*k +: 4] = dig_q[4*k +: 4];
      end
    end
  end

  assign top_zero = (dig_q[ipa_pkg::DIG_W-1 -: 4] == 4'd0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipa_pkg::CV_DABBLE: begin
        if (bit_q == 5'd31) state_d = ipa_pkg::CV_NORM;
      end
      ipa_pkg::CV_NORM: begin
        if (cnt_q == 4'd1 || !top_zero) state_d = ipa_pkg::CV_HOLD;
      end
      default: ;
    endcase
    if (cmd_i.start) begin
      state_d = cmd_i.hex ? ipa_pkg::CV_NORM : ipa_pkg::CV_DABBLE;
    end
  end

  // datapath updates
  always_comb begin
    dig_d = dig_q;
    bin_d = bin_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      if (cmd_i.hex) begin
        dig_d = {cmd_i.mag, 8'h00};
        cnt_d = 4'(ipa_pkg::HEX_DIGITS);
      end else begin
        dig_d = '0;
        bin_d = cmd_i.mag;
        cnt_d = 4'(ipa_pkg::NUM_DIGITS);
      end
      bit_d = '0;
    end else begin
      case (state_q)
        ipa_pkg::CV_DABBLE: begin
          dig_d = {dig_adj[ipa_pkg::DIG_W-2:0], bin_q[ipa_pkg::VAL_W-1]};
          bin_d = {bin_q[ipa_pkg::VAL_W-2:0], 1'b0};
          bit_d = bit_q + 5'd1;
        end
        ipa_pkg::CV_NORM: begin
          // drop leading zero digits, keeping at least one
          if (cnt_q != 4'd1 && top_zero) begin
            dig_d = {dig_q[ipa_pkg::DIG_W-5:0], 4'h0};
            cnt_d = cnt_q - 4'd1;
          end
        end
        ipa_pkg::CV_HOLD: begin
          if (cmd_i.pop) dig_d = {dig_q[ipa_pkg::DIG_W-5:0], 4'h0};
        end
        default: ;
      endcase
    end
  end

  // status outputs
  always_comb begin
    sts_o.done      = (state_q == ipa_pkg::CV_HOLD);
    sts_o.digit_cnt = cnt_q;
    sts_o.top_digit = dig_q[ipa_pkg::DIG_W-1 -: 4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipa_pkg::CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
    bit_q <= bit_d;
    cnt_q <= cnt_d;
  end

endmodule
